// File: src/assert_macros.svh
// assertion macros for the rtl files (included by aes128_block_cipher)
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property must hold on every clock when out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// antecedent implies consequent on the next clock
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: src/aes_pkg.sv
// aes package: payload types, sbox table and column helpers
// no dependencies
`default_nettype none
package aes_pkg;
    localparam int ROUND_COUNT = 10;
    localparam int SCHED_WORDS = 4 * (ROUND_COUNT + 1);
    localparam int KIDX_W = $clog2(SCHED_WORDS);
    localparam int RND_W = $clog2(ROUND_COUNT + 1);
    localparam logic [0:0] CMD_ENC = 1'b0;
    localparam logic [0:0] CMD_DEC = 1'b1;
    localparam logic [0:0] REG_KEY_HIGH = 1'b0;
    localparam logic [0:0] REG_KEY_LOW = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [63:0] block_high;
        logic [63:0] block_low;
    } t_in;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } t_out;

    localparam logic [7:0] FWD_BOX [256] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    endfunction

    // inverse sbox: searches the forward table for the entry equal to v
    function automatic logic [7:0] inv_sbox(input logic [7:0] v);
        logic [7:0] r;
        r = 8'h00;
        for (int i = 0; i < 256; i++) begin
            if (FWD_BOX[i] == v) r = i[7:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] x);
        return {FWD_BOX[x[31:24]], FWD_BOX[x[23:16]], FWD_BOX[x[15:8]], FWD_BOX[x[7:0]]};
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] c);
        logic [7:0] a0, a1, a2, a3;
        a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
        return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
    endfunction

    // inverse mix as a pre-step (x4 terms) followed by the forward mix
    function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
        logic [7:0] a0, a1, a2, a3, u, v;
        a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
        u = xtime(xtime(a0 ^ a2));
        v = xtime(xtime(a1 ^ a3));
        return mix_col({a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v});
    endfunction
endpackage
`default_nettype wire

// File: src/aes_round.sv
// shared aes round datapath, forward or inverse, with optional mix
// depends on aes_pkg
`default_nettype none
module aes_round import aes_pkg::*; (
    input  wire logic [127:0] i_state,
    input  wire logic         i_inverse,
    input  wire logic         i_mix,
    input  wire logic [127:0] i_key,
    output logic      [127:0] o_state
);
    logic [7:0]   s [16];
    logic [7:0]   t [16];
    logic [127:0] sub;
    logic [127:0] mixed;

    always_comb begin
        for (int i = 0; i < 16; i++) s[i] = i_state[127 - 8*i -: 8];
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                if (i_inverse) t[r + 4*((c + r) % 4)] = inv_sbox(s[r + 4*c]);
                else t[r + 4*c] = FWD_BOX[s[r + 4*((c + r) % 4)]];
            end
        end
        for (int i = 0; i < 16; i++) sub[127 - 8*i -: 8] = t[i];
        // inverse round: key added before inverse mix
        for (int c = 0; c < 4; c++) begin
            if (i_inverse)
                mixed[127 - 32*c -: 32] = inv_mix_col(sub[127 - 32*c -: 32] ^
                                                      i_key[127 - 32*c -: 32]);
            else
                mixed[127 - 32*c -: 32] = mix_col(sub[127 - 32*c -: 32]) ^
                                          i_key[127 - 32*c -: 32];
        end
        o_state = i_mix ? mixed : (sub ^ i_key);
    end
endmodule
`default_nettype wire

// File: src/aes128_block_cipher.sv
// aes-128 encrypt/decrypt top level with key schedule cache
// depends on aes_pkg, aes_round, assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
// One transaction takes one 128-bit block and a cmd bit (0 encrypt, 1
// decrypt) and returns one 128-bit block, byte 0 in the top bits. A single
// round unit is reused for every round. The 44-word schedule memory is read
// one word per cycle, so each round key is fetched in ST_FETCH as four word
// reads through the registered read port and applied in ST_ROUND. After the
// initial key add and ten rounds, ST_DONE loads the output register. The
// first block after reset or a key write first expands the key into all 44
// schedule words, one schedule word per cycle. Input stall is high while a
// block is in flight, while the result waits and while a key write is
// pending, so a new block is accepted only once the result has been taken.
// Key writes are taken only while idle and take priority over a new block.
module aes128_block_cipher import aes_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in         i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out             o_out_data
);
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_EXP   = 5'b00010,
        ST_FETCH = 5'b00100,
        ST_ROUND = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

    t_state       r_st, n_st;
    logic [63:0]  r_key_hi, r_key_lo;
    logic         r_sched_ok;
    logic [31:0]  r_mem [SCHED_WORDS];
    logic [31:0]  r_rd;
    logic [KIDX_W-1:0] r_widx;      // expansion write index
    logic [31:0]  r_w [4];          // last four schedule words
    logic [7:0]   r_rcon;
    logic         r_dec;
    logic [127:0] r_blk;
    logic [127:0] r_kbuf;
    logic [RND_W-1:0] r_rnd;        // rounds done
    logic [2:0]   r_fc;             // fetch cycle count
    logic         r_init;           // next key is the initial add
    logic         r_ovld;
    t_out         r_out;

    logic [31:0]  w_new, w_tmp;
    logic [127:0] w_round;
    logic [KIDX_W-1:0] w_ridx;
    logic [RND_W-1:0]  w_krnd;
    logic         w_last;

    assign o_cfg_ready = (r_st == ST_IDLE) && !r_ovld;
    // a pending key write goes first so the block sees the new key
    assign o_in_stall  = (r_st != ST_IDLE) || r_ovld || i_cfg_valid;
    assign o_out_valid = r_ovld;
    assign o_out_data  = r_out;

    // key schedule word
    always_comb begin
        w_tmp = r_w[3];
        if (r_widx[1:0] == 2'd0)
            w_tmp = sub_word({r_w[3][23:0], r_w[3][31:24]}) ^ {r_rcon, 24'h0};
        w_new = r_w[0] ^ w_tmp;
    end

    // key round being fetched
    always_comb begin
        if (r_init) w_krnd = r_dec ? RND_W'(ROUND_COUNT) : '0;
        else w_krnd = r_dec ? RND_W'(ROUND_COUNT - 1) - r_rnd : r_rnd + 1'b1;
        w_ridx = KIDX_W'({w_krnd, 2'b00}) + KIDX_W'(r_fc[1:0]);
        w_last = (r_rnd == RND_W'(ROUND_COUNT - 1));
    end

    aes_round u_round (
        .i_state   (r_blk),
        .i_inverse (r_dec),
        .i_mix     (!w_last),
        .i_key     (r_kbuf),
        .o_state   (w_round)
    );

    always_ff @(posedge i_clk) begin
        if (r_st == ST_EXP) r_mem[r_widx] <= (r_widx < KIDX_W'(4)) ? r_w[r_widx[1:0]] : w_new;
        r_rd <= r_mem[w_ridx];
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE:  if (i_in_valid && !o_in_stall) n_st = r_sched_ok ? ST_FETCH : ST_EXP;
            ST_EXP:   if (r_widx == KIDX_W'(SCHED_WORDS - 1)) n_st = ST_FETCH;
            ST_FETCH: if (r_fc == 3'd4) n_st = ST_ROUND;
            ST_ROUND: n_st = (r_init || !w_last) ? ST_FETCH : ST_DONE;
            ST_DONE:  n_st = ST_IDLE;
            default:  n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_key_hi <= '0;
            r_key_lo <= '0;
            r_sched_ok <= 1'b0;
            r_ovld <= 1'b0;
        end else begin
            r_st <= n_st;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_KEY_HIGH: r_key_hi <= i_cfg_data;
                    REG_KEY_LOW:  r_key_lo <= i_cfg_data;
                    default: ;
                endcase
                r_sched_ok <= 1'b0;
            end
            if (r_st == ST_EXP && n_st == ST_FETCH) r_sched_ok <= 1'b1;
            if (r_st == ST_DONE) r_ovld <= 1'b1;
            else if (r_ovld && !i_out_stall) r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            ST_IDLE: begin
                r_dec <= i_in_data.cmd;
                r_blk <= {i_in_data.block_high, i_in_data.block_low};
                r_widx <= '0;
                r_w[0] <= r_key_hi[63:32];
                r_w[1] <= r_key_hi[31:0];
                r_w[2] <= r_key_lo[63:32];
                r_w[3] <= r_key_lo[31:0];
                r_rcon <= 8'h01;
                r_fc <= '0;
                r_rnd <= '0;
                r_init <= 1'b1;
            end
            ST_EXP: begin
                r_widx <= r_widx + 1'b1;
                if (r_widx >= KIDX_W'(4)) begin
                    r_w[0] <= r_w[1];
                    r_w[1] <= r_w[2];
                    r_w[2] <= r_w[3];
                    r_w[3] <= w_new;
                    if (r_widx[1:0] == 2'd0) r_rcon <= xtime(r_rcon);
                end
            end
            ST_FETCH: begin
                // read data is registered in r_rd, so it lags its address
                r_fc <= r_fc + 1'b1;
                if (r_fc != 3'd0) r_kbuf <= {r_kbuf[95:0], r_rd};
            end
            ST_ROUND: begin
                r_fc <= '0;
                if (r_init) begin
                    r_blk <= r_blk ^ r_kbuf;
                    r_init <= 1'b0;
                end else begin
                    r_blk <= w_round;
                    r_rnd <= r_rnd + 1'b1;
                end
            end
            ST_DONE: r_out <= '{result_high: r_blk[127:64], result_low: r_blk[63:0]};
            default: ;
        endcase
    end

    `ASSERT_ALWAYS(a_stall_busy, i_clk, i_rst_n, (r_st != ST_IDLE) |-> o_in_stall)
    `ASSERT_NEXT(a_done_valid, i_clk, i_rst_n, r_st == ST_DONE, o_out_valid)
    `ASSERT_NEXT(a_sched_after_exp, i_clk, i_rst_n, r_st == ST_EXP && n_st == ST_FETCH, r_sched_ok)
endmodule
`default_nettype wire

// File: sim/aes128_block_cipher_test.sv
// testbench for the aes-128 block cipher: directed and random blocks under idling
// depends on aes_pkg and aes128_block_cipher
`default_nettype none
module aes128_block_cipher_test;
    import aes_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 200;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [0:0]  i_cfg_index;
    logic [63:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in         i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out        o_out_data;

    aes128_block_cipher uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data)
    );

    // predictor state: key registers and the cached schedule
    logic [63:0] key_hi_q, key_lo_q;
    logic [31:0] sched_words [SCHED_WORDS];
    bit          sched_ok;
    logic [7:0]  sbox_inv [256];

    t_out        expected_blocks [$];
    int          fail_count;
    int          sent_count;
    int          enc_count, dec_count;
    int          idle_pct_in, stall_pct_out;
    int          quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) acc ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
        end
        return acc;
    endfunction

    function automatic void expand_schedule();
        logic [31:0] t;
        logic [7:0]  rc;
        rc = 8'h01;
        sched_words[0] = key_hi_q[63:32];
        sched_words[1] = key_hi_q[31:0];
        sched_words[2] = key_lo_q[63:32];
        sched_words[3] = key_lo_q[31:0];
        for (int i = 4; i < SCHED_WORDS; i++) begin
            t = sched_words[i-1];
            if (i % 4 == 0) begin
                t = {t[23:0], t[31:24]};
                t = {FWD_BOX[t[31:24]], FWD_BOX[t[23:16]], FWD_BOX[t[15:8]],
                     FWD_BOX[t[7:0]]} ^ {rc, 24'h0};
                rc = gmul(rc, 8'h02);
            end
            sched_words[i] = sched_words[i-4] ^ t;
        end
        sched_ok = 1'b1;
    endfunction

    // state as 16 bytes, index 4*col+row
    typedef logic [7:0] t_state [16];

    function automatic void add_round_key(ref t_state s, input int rnd);
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                s[4*c+r] ^= sched_words[4*rnd+c][31-8*r -: 8];
    endfunction

    function automatic void sub_and_shift(ref t_state s, input bit inv);
        t_state t;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) begin
                if (inv) t[r + 4*((c+r)&3)] = sbox_inv[s[r+4*c]];
                else     t[r + 4*c] = FWD_BOX[s[r + 4*((c+r)&3)]];
            end
        s = t;
    endfunction

    function automatic void mix_columns(ref t_state s, input bit inv);
        logic [7:0] coef [4];
        logic [7:0] col [4];
        logic [7:0] v;
        if (inv) coef = '{8'd14, 8'd11, 8'd13, 8'd9};
        else     coef = '{8'd2, 8'd3, 8'd1, 8'd1};
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) col[k] = s[4*c+k];
            for (int r = 0; r < 4; r++) begin
                v = 8'h00;
                for (int k = 0; k < 4; k++) v ^= gmul(col[k], coef[(k-r+4)&3]);
                s[4*c+r] = v;
            end
        end
    endfunction

    function automatic t_out cipher_block(input t_in item);
        t_state s;
        t_out   res;
        if (!sched_ok) expand_schedule();
        for (int i = 0; i < 8; i++) begin
            s[i]   = item.block_high[63-8*i -: 8];
            s[8+i] = item.block_low[63-8*i -: 8];
        end
        if (item.cmd == CMD_ENC) begin
            add_round_key(s, 0);
            for (int rnd = 1; rnd < ROUND_COUNT; rnd++) begin
                sub_and_shift(s, 1'b0);
                mix_columns(s, 1'b0);
                add_round_key(s, rnd);
            end
            sub_and_shift(s, 1'b0);
            add_round_key(s, ROUND_COUNT);
        end else begin
            add_round_key(s, ROUND_COUNT);
            for (int rnd = ROUND_COUNT - 1; rnd > 0; rnd--) begin
                sub_and_shift(s, 1'b1);
                add_round_key(s, rnd);
                mix_columns(s, 1'b1);
            end
            sub_and_shift(s, 1'b1);
            add_round_key(s, 0);
        end
        for (int i = 0; i < 8; i++) begin
            res.result_high[63-8*i -: 8] = s[i];
            res.result_low[63-8*i -: 8]  = s[8+i];
        end
        return res;
    endfunction

    // send one block; valid stays up while stalled, payload frozen
    // valid is dropped by the next idle cycle or by the caller
    task automatic send_block(input logic cmd, input logic [63:0] hi, input logic [63:0] lo);
        t_in item;
        item.cmd = cmd;
        item.block_high = hi;
        item.block_low = lo;
        while ($urandom_range(99) < idle_pct_in) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
        expected_blocks.push_back(cipher_block(item));
        sent_count++;
        if (cmd == CMD_DEC) dec_count++; else enc_count++;
    endtask

    // wait until idle, then write a key register
    task automatic write_key(input logic [0:0] idx, input logic [63:0] value);
        i_in_valid <= 1'b0;
        while (expected_blocks.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_KEY_HIGH) key_hi_q = value; else key_lo_q = value;
        sched_ok = 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // receiver: random stall, compare every transaction with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_blocks.size() == 0) begin
                    $error("unexpected result %h", o_out_data);
                    fail_count++;
                end else begin
                    t_out want;
                    want = expected_blocks.pop_front();
                    if (o_out_data.result_high !== want.result_high) begin
                        $error("result_high expected %h actual %h",
                               want.result_high, o_out_data.result_high);
                        fail_count++;
                    end
                    if (o_out_data.result_low !== want.result_low) begin
                        $error("result_low expected %h actual %h",
                               want.result_low, o_out_data.result_low);
                        fail_count++;
                    end
                end
            end
            i_out_stall <= ($urandom_range(99) < stall_pct_out);
        end
    end

    // watchdog on cycles without any accepted transaction
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results pending", expected_blocks.size());
            $display("** aes128_block_cipher: FAILED **");
            $finish;
        end
    end

    // known vectors and extremes, including a block before any key write
    task automatic test_directed();
        send_block(CMD_ENC, 64'h0, 64'h0);
        send_block(CMD_DEC, 64'h0, 64'h0);
        send_block(CMD_ENC, '1, '1);
        write_key(REG_KEY_HIGH, 64'h2b7e151628aed2a6);
        write_key(REG_KEY_LOW, 64'habf7158809cf4f3c);
        send_block(CMD_ENC, 64'h3243f6a8885a308d, 64'h313198a2e0370734);
        send_block(CMD_DEC, 64'h3925841d02dc09fb, 64'hdc118597196a0b32);
        write_key(REG_KEY_HIGH, 64'h0001020304050607);
        write_key(REG_KEY_LOW, 64'h08090a0b0c0d0e0f);
        send_block(CMD_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block(CMD_DEC, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
        send_block(CMD_DEC, '1, '1);
        write_key(REG_KEY_HIGH, '1);
        write_key(REG_KEY_LOW, '1);
        send_block(CMD_ENC, 64'h0, 64'h0);
        send_block(CMD_DEC, '1, 64'h0);
        send_block(CMD_ENC, 64'h8000000000000000, 64'h1);
        // only one key half changed
        write_key(REG_KEY_LOW, 64'h0);
        send_block(CMD_DEC, 64'h1, 64'h8000000000000000);
    endtask

    // random blocks and keys under one idling setting
    task automatic test_random(input int count, input int idle_in, input int stall_out);
        idle_pct_in = idle_in;
        stall_pct_out = stall_out;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(49) == 0)
                write_key(1'($urandom_range(1)), rand64());
            send_block(1'($urandom_range(1)), rand64(), rand64());
        end
    endtask

    initial begin
        fail_count = 0;
        sent_count = 0;
        enc_count = 0;
        dec_count = 0;
        quiet_cycles = 0;
        idle_pct_in = 0;
        stall_pct_out = 0;
        key_hi_q = '0;
        key_lo_q = '0;
        sched_ok = 1'b0;
        for (int i = 0; i < 256; i++) sbox_inv[FWD_BOX[i]] = i[7:0];
        i_rst_n <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= REG_KEY_HIGH;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        i_out_stall <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(600, 0, 0);
        test_random(450, 72, 0);
        test_random(450, 0, 72);
        test_random(450, 6, 6);
        i_in_valid <= 1'b0;

        while (expected_blocks.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d blocks (%0d encrypt, %0d decrypt) over several keys",
                 sent_count, enc_count, dec_count);
        $display("idling phases: none, sender idle, receiver stall, light mixed");
        if (fail_count == 0)
            $display("** aes128_block_cipher: PASSED **");
        else
            $display("** aes128_block_cipher: FAILED **");
        $finish;
    end
endmodule
`default_nettype wire

// File: files.f
+incdir+src
src/aes_pkg.sv
src/aes_round.sv
src/aes128_block_cipher.sv
sim/aes128_block_cipher_test.sv
